// ===== rtl/core/hrf_pkg.sv =====
// Shared types, codes and constants of the HTTP request framer.
// Used by every module of the framer; depends on nothing else.
package hrf_pkg;

  // One received byte and its connection marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } hrf_in_t;

  // One framing result for one received byte.
  typedef struct packed {
    logic [2:0]  frame_status;
    logic [31:0] request_length;
    logic [31:0] body_length;
  } hrf_out_t;

  typedef struct packed {
    logic [31:0] header_limit;
    logic [31:0] request_limit;
  } hrf_limits_t;

  localparam logic [2:0] ST_NEED_MORE   = 3'd0;
  localparam logic [2:0] ST_DONE        = 3'd1;
  localparam logic [2:0] ST_HDR_LARGE   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
  localparam logic [2:0] ST_DROPPED     = 3'd5;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LIMIT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_LIMIT = 8'd1;

  localparam logic [31:0] HEADER_LIMIT_RESET  = 32'd8192;
  localparam logic [31:0] REQUEST_LIMIT_RESET = 32'd1048576;

  // Position within the current header line.
  localparam logic [2:0] LP_NAME_LEAD    = 3'd0;
  localparam logic [2:0] LP_NAME_BODY    = 3'd1;
  localparam logic [2:0] LP_NAME_TRAIL   = 3'd2;
  localparam logic [2:0] LP_VALUE_LEAD   = 3'd3;
  localparam logic [2:0] LP_VALUE_DIGITS = 3'd4;
  localparam logic [2:0] LP_VALUE_TRAIL  = 3'd5;
  localparam logic [2:0] LP_SKIP         = 3'd6;

  // Header scanner state: terminator progress, line position, name match
  // and the content length being collected.
  typedef struct packed {
    logic [1:0]  term;
    logic [2:0]  part;
    logic [3:0]  idx;
    logic        still;
    logic        found;
    logic        invalid;
    logic [63:0] value;
  } hrf_scan_t;

  localparam hrf_scan_t SCAN_CLEAR = '{
    term:    2'd0,
    part:    LP_NAME_LEAD,
    idx:     4'd0,
    still:   1'b1,
    found:   1'b0,
    invalid: 1'b0,
    value:   64'd0
  };

endpackage

// ===== rtl/core/hrf_header_scan.sv =====
// Header scanner of the HTTP request framer: terminator search, line split,
// content-length name match and decimal value collection for one byte.
// Depends on hrf_pkg.
module hrf_header_scan (
  input  hrf_pkg::hrf_scan_t scan,
  input  logic [7:0]         data_byte,
  output hrf_pkg::hrf_scan_t scan_next,
  output logic               done
);
  import hrf_pkg::*;

  localparam logic [1:0] TP_NONE    = 2'd0;
  localparam logic [1:0] TP_CR      = 2'd1;
  localparam logic [1:0] TP_CRLF    = 2'd2;
  localparam logic [1:0] TP_CRLFCR  = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [3:0] KEY_LEN  = 4'd14;

  function automatic logic [7:0] key_char(input logic [3:0] i);
    logic [7:0] k;
    unique case (i)
      4'd0:    k = "c";
      4'd1:    k = "o";
      4'd2:    k = "n";
      4'd3:    k = "t";
      4'd4:    k = "e";
      4'd5:    k = "n";
      4'd6:    k = "t";
      4'd7:    k = "-";
      4'd8:    k = "l";
      4'd9:    k = "e";
      4'd10:   k = "n";
      4'd11:   k = "g";
      4'd12:   k = "t";
      4'd13:   k = "h";
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic hrf_scan_t mark_bad(input hrf_scan_t s);
    hrf_scan_t r;
    r = s;
    r.invalid = 1'b1;
    r.part    = LP_SKIP;
    return r;
  endfunction

  function automatic hrf_scan_t name_char(input hrf_scan_t s, input logic [7:0] c);
    hrf_scan_t r;
    logic [7:0] lc;
    r  = s;
    lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    if (s.still && s.idx < KEY_LEN && lc == key_char(s.idx)) begin
      r.idx = s.idx + 4'd1;
    end else begin
      r.still = 1'b0;
    end
    return r;
  endfunction

  function automatic hrf_scan_t name_colon(input hrf_scan_t s);
    hrf_scan_t r;
    r = s;
    if (s.still && s.idx == KEY_LEN) begin
      r.found = 1'b1;
      r.value = 64'd0;
      r.part  = LP_VALUE_LEAD;
    end else begin
      r.part = LP_SKIP;
    end
    return r;
  endfunction

  // value * 10 + digit; anything reaching past 64 bits is an overflow.
  function automatic hrf_scan_t add_digit(input hrf_scan_t s, input logic [7:0] c);
    hrf_scan_t r;
    logic [67:0] prod;
    r    = s;
    prod = ({4'd0, s.value} << 3) + ({4'd0, s.value} << 1) + {60'd0, c - CH_ZERO};
    if (prod[67:64] != 4'd0) begin
      r = mark_bad(s);
    end else begin
      r.value = prod[63:0];
    end
    return r;
  endfunction

  function automatic hrf_scan_t line_char(input hrf_scan_t s, input logic [7:0] c);
    hrf_scan_t r;
    logic blank;
    logic digit;
    logic colon;
    r     = s;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    colon = (c == CH_COLON);
    unique case (s.part)
      LP_NAME_LEAD: begin
        if (blank) begin
          r = s;
        end else if (colon) begin
          r = name_colon(s);
        end else begin
          r      = name_char(s, c);
          r.part = LP_NAME_BODY;
        end
      end
      LP_NAME_BODY: begin
        if (blank) r.part = LP_NAME_TRAIL;
        else if (colon) r = name_colon(s);
        else r = name_char(s, c);
      end
      LP_NAME_TRAIL: begin
        if (colon) begin
          r = name_colon(s);
        end else if (!blank) begin
          r.still = 1'b0;
          r.part  = LP_NAME_BODY;
        end
      end
      LP_VALUE_LEAD: begin
        if (digit) begin
          r      = add_digit(s, c);
          if (!r.invalid) r.part = LP_VALUE_DIGITS;
        end else if (!blank) begin
          r = mark_bad(s);
        end
      end
      LP_VALUE_DIGITS: begin
        if (digit) r = add_digit(s, c);
        else if (blank) r.part = LP_VALUE_TRAIL;
        else r = mark_bad(s);
      end
      LP_VALUE_TRAIL: begin
        if (!blank) r = mark_bad(s);
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  function automatic hrf_scan_t close_line(input hrf_scan_t s);
    hrf_scan_t r;
    r = s;
    if (s.part == LP_VALUE_LEAD) r.invalid = 1'b1;
    r.part  = s.found ? LP_SKIP : LP_NAME_LEAD;
    r.idx   = 4'd0;
    r.still = 1'b1;
    return r;
  endfunction

  // A CR that turns out not to start a line break is replayed as an
  // ordinary line character before the current byte.
  always_comb begin
    scan_next = scan;
    done      = 1'b0;
    unique case (scan.term)
      TP_NONE: begin
        if (data_byte == CH_CR) scan_next.term = TP_CR;
        else scan_next = line_char(scan, data_byte);
      end
      TP_CR, TP_CRLFCR: begin
        if (data_byte == CH_LF) begin
          if (scan.term == TP_CRLFCR) begin
            scan_next.term = TP_NONE;
            done           = 1'b1;
          end else begin
            scan_next      = close_line(scan);
            scan_next.term = TP_CRLF;
          end
        end else begin
          scan_next = line_char(scan, CH_CR);
          if (data_byte == CH_CR) begin
            scan_next.term = TP_CR;
          end else begin
            scan_next      = line_char(scan_next, data_byte);
            scan_next.term = TP_NONE;
          end
        end
      end
      default: begin
        if (data_byte == CH_CR) begin
          scan_next.term = TP_CRLFCR;
        end else begin
          scan_next      = line_char(scan, data_byte);
          scan_next.term = TP_NONE;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/hrf_framer.sv =====
// Framing state of the HTTP request framer: phase, byte count, limit checks
// and the result for each byte. Depends on hrf_pkg and hrf_header_scan.
module hrf_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  hrf_pkg::hrf_in_t     item,
  input  hrf_pkg::hrf_limits_t limits,
  output hrf_pkg::hrf_out_t    result
);
  import hrf_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [31:0] byte_count;
  logic [31:0] byte_count_next;
  logic [31:0] request_end;
  logic [31:0] request_end_next;
  hrf_scan_t   scan;
  hrf_scan_t   scan_next;

  logic [1:0]  cur_phase;
  logic [31:0] cur_count;
  logic [31:0] count_plus;
  logic [31:0] count_hdr;
  logic [63:0] body;
  logic        overflow;
  hrf_scan_t   cur_scan;
  hrf_scan_t   scanned;
  logic        done;

  hrf_header_scan u_scan (
    .scan      (cur_scan),
    .data_byte (item.data_byte),
    .scan_next (scanned),
    .done      (done)
  );

  always_comb begin
    cur_phase  = item.new_connection ? PH_HEADER : phase;
    cur_count  = item.new_connection ? 32'd0 : byte_count;
    cur_scan   = item.new_connection ? SCAN_CLEAR : scan;
    count_plus = cur_count + 32'd1;
    overflow   = &cur_count;
    count_hdr  = overflow ? cur_count : count_plus;
    body       = scanned.found ? scanned.value : 64'd0;

    phase_next       = cur_phase;
    byte_count_next  = cur_count;
    scan_next        = cur_scan;
    request_end_next = request_end;
    result           = '0;

    unique case (cur_phase)
      PH_HEADER: begin
        scan_next       = scanned;
        byte_count_next = count_hdr;
        if (overflow || count_hdr > limits.header_limit) begin
          result.frame_status = ST_HDR_LARGE;
        end else if (!done) begin
          if (count_hdr > limits.request_limit) result.frame_status = ST_TOO_LARGE;
        end else if (scanned.found && scanned.invalid) begin
          result.frame_status = ST_BAD_LENGTH;
        end else if (count_hdr > limits.request_limit ||
                     body > {32'd0, limits.request_limit - count_hdr}) begin
          result.frame_status = ST_TOO_LARGE;
        end else if (body == 64'd0) begin
          result.frame_status   = ST_DONE;
          result.request_length = count_hdr;
          phase_next            = PH_HEADER;
          byte_count_next       = 32'd0;
          scan_next             = SCAN_CLEAR;
        end else begin
          // The body fits under request_limit, so the end count fits 32 bits.
          request_end_next = count_hdr + body[31:0];
          phase_next       = PH_BODY;
        end
        if (result.frame_status >= ST_HDR_LARGE) phase_next = PH_ERROR;
      end
      PH_BODY: begin
        byte_count_next = count_plus;
        if (count_plus == request_end) begin
          result.frame_status   = ST_DONE;
          result.request_length = count_plus;
          result.body_length    = cur_scan.value[31:0];
          phase_next            = PH_HEADER;
          byte_count_next       = 32'd0;
          scan_next             = SCAN_CLEAR;
        end
      end
      default: begin
        result.frame_status = ST_DROPPED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_count <= 32'd0;
      scan       <= SCAN_CLEAR;
    end else if (step) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      scan       <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) request_end <= request_end_next;
  end

endmodule

// ===== rtl/core/http_request_framer.sv =====
// Top level of the HTTP request framer: byte channel, result channel and
// limit registers. Depends on hrf_pkg and hrf_framer.
//
// Usage:
//   byte channel  (byte_valid, byte_ready, byte_item): one received byte per
//     item; new_connection set on the first byte of a connection clears all
//     framing state before that byte is handled.
//   frame channel (frame_valid, frame_ready, frame_item): exactly one result
//     item per byte item, in order. Status 1 marks the last byte of a request
//     and carries its total and body lengths; statuses 2 to 4 report an error,
//     after which every byte reports 5 until the next new connection.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 writes
//     header_limit, index 1 writes request_limit, other indexes are ignored.
//     cfg_ready is always high; write only while no byte is in flight.
// Timing: an accepted byte is held in the input register, and its result is
//   registered on frame_item when that byte advances. One byte per cycle is
//   sustained while frame_ready stays high; the whole per-byte update sits
//   between the input register and the result register.
// Reset: both pipeline registers empty, framing state cleared, limits back to
//   8192 and 1048576. When a result is offered and frame_ready is low, it holds;
//   a byte is taken only into an empty input register, and byte_ready then drops.
module http_request_framer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_ready,
  input  hrf_pkg::hrf_in_t                    byte_item,
  output logic                                frame_valid,
  input  logic                                frame_ready,
  output hrf_pkg::hrf_out_t                   frame_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hrf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data
);
  import hrf_pkg::*;

  hrf_limits_t limits;
  logic        hold_valid;
  hrf_in_t     hold_item;
  logic        advance;
  logic        step;
  hrf_out_t    result;

  assign cfg_ready  = 1'b1;
  assign advance    = !frame_valid || frame_ready;
  assign byte_ready = !hold_valid || advance;
  assign step       = hold_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.header_limit  <= HEADER_LIMIT_RESET;
      limits.request_limit <= REQUEST_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER_LIMIT:  limits.header_limit  <= cfg_data;
        CFG_REQUEST_LIMIT: limits.request_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_ready) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) hold_item <= byte_item;
  end

  hrf_framer u_framer (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_item),
    .limits (limits),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (advance) begin
      frame_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) frame_item <= result;
  end

endmodule

// ===== rtl/core/hrf_checker.sv =====
// Port-level checks of the HTTP request framer result channel, bound to the
// top level. Depends on hrf_pkg.
module hrf_checker (
  input logic              clk,
  input logic              rst,
  input logic              frame_valid,
  input logic              frame_ready,
  input hrf_pkg::hrf_out_t frame_item
);
  import hrf_pkg::*;

  // A stalled result stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(frame_item))
    else $error("result changed while stalled");

  // Reset leaves the result channel empty.
  a_reset: assert property (@(posedge clk)
    rst |=> !frame_valid)
    else $error("result offered right after reset");

  // Lengths are reported only on the last byte of a request.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_item.frame_status != ST_DONE |->
      frame_item.request_length == 32'd0 && frame_item.body_length == 32'd0)
    else $error("lengths reported without a finished request");

  // A finished request always holds at least its four-byte terminator.
  a_len: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_item.frame_status == ST_DONE |->
      frame_item.request_length > frame_item.body_length)
    else $error("request length not above body length");

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_valid (frame_valid),
  .frame_ready (frame_ready),
  .frame_item  (frame_item)
);

// ===== tb/http_request_framer_tb.sv =====
// Self-checking testbench for http_request_framer: drives bytes and limit writes,
// predicts every frame result in place and compares it field by field.
// Depends on hrf_pkg and the framer RTL only.
module http_request_framer_tb;
  import hrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int KEY_LEN = 14;
  localparam logic [8*KEY_LEN-1:0] LENGTH_KEY = "content-length";
  localparam logic [7:0] ASCII_TAB = 8'd9;
  localparam logic [7:0] ASCII_LF  = 8'd10;
  localparam logic [7:0] ASCII_CR  = 8'd13;
  localparam logic [7:0] ASCII_SP  = 8'd32;

  typedef enum logic [1:0] {PHASE_HEADER, PHASE_BODY, PHASE_ERROR} phase_t;

  logic clk = 1'b0;
  logic rst;
  logic byte_valid;
  logic byte_ready;
  hrf_in_t byte_item;
  logic frame_valid;
  logic frame_ready = 1'b1;
  hrf_out_t frame_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  http_request_framer u_top (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item(byte_item),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame_item(frame_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Framing state kept by the predictor.
  logic [31:0] lim_header;
  logic [31:0] lim_request;
  phase_t      frame_phase;
  logic [31:0] byte_total;
  logic [1:0]  crlf_seen;
  logic [2:0]  line_pos;
  logic [3:0]  key_pos;
  bit          key_alive;
  bit          len_seen;
  bit          len_bad;
  logic [63:0] len_value;
  logic [31:0] head_size;

  hrf_out_t expected_frames[$];
  hrf_out_t oldest_frame;
  logic [7:0] request_bytes[$];
  int unsigned sent_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int ready_hold = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_frame_state();
    frame_phase = PHASE_HEADER;
    byte_total = '0;
    crlf_seen = '0;
    line_pos = LP_NAME_LEAD;
    key_pos = '0;
    key_alive = 1'b1;
    len_seen = 1'b0;
    len_bad = 1'b0;
    len_value = '0;
    head_size = '0;
  endfunction

  function automatic void flag_bad_length();
    len_bad = 1'b1;
    line_pos = LP_SKIP;
  endfunction

  function automatic void take_digit(logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - 8'd48};
    if (len_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) flag_bad_length();
    else len_value = len_value * 64'd10 + d;
  endfunction

  function automatic void match_name_char(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (key_alive && key_pos < KEY_LEN &&
        lc == LENGTH_KEY[8*(KEY_LEN-1-key_pos) +: 8])
      key_pos++;
    else
      key_alive = 1'b0;
  endfunction

  function automatic void close_name();
    if (key_alive && key_pos == KEY_LEN) begin
      len_seen = 1'b1;
      len_value = '0;
      line_pos = LP_VALUE_LEAD;
    end else begin
      line_pos = LP_SKIP;
    end
  endfunction

  function automatic void scan_line_char(logic [7:0] c);
    bit blank;
    bit digit;
    blank = (c == ASCII_SP || c == ASCII_TAB);
    digit = (c >= "0" && c <= "9");
    case (line_pos)
      LP_NAME_LEAD: begin
        if (c == ":") close_name();
        else if (!blank) begin
          match_name_char(c);
          line_pos = LP_NAME_BODY;
        end
      end
      LP_NAME_BODY: begin
        if (blank) line_pos = LP_NAME_TRAIL;
        else if (c == ":") close_name();
        else match_name_char(c);
      end
      LP_NAME_TRAIL: begin
        if (c == ":") close_name();
        else if (!blank) begin
          key_alive = 1'b0;
          line_pos = LP_NAME_BODY;
        end
      end
      LP_VALUE_LEAD: begin
        if (digit) begin
          line_pos = LP_VALUE_DIGITS;
          take_digit(c);
        end else if (!blank) begin
          flag_bad_length();
        end
      end
      LP_VALUE_DIGITS: begin
        if (digit) take_digit(c);
        else if (blank) line_pos = LP_VALUE_TRAIL;
        else flag_bad_length();
      end
      LP_VALUE_TRAIL: begin
        if (!blank) flag_bad_length();
      end
      default: ;
    endcase
  endfunction

  function automatic void finish_line();
    if (line_pos == LP_VALUE_LEAD) len_bad = 1'b1;
    line_pos = len_seen ? LP_SKIP : LP_NAME_LEAD;
    key_pos = '0;
    key_alive = 1'b1;
  endfunction

  // Returns 1 when this byte completes the blank line that ends the header.
  function automatic bit scan_header_byte(logic [7:0] c);
    bit ended;
    ended = 1'b0;
    case (crlf_seen)
      2'd0: begin
        if (c == ASCII_CR) crlf_seen = 2'd1;
        else scan_line_char(c);
      end
      2'd1, 2'd3: begin
        if (c == ASCII_LF) begin
          if (crlf_seen == 2'd3) begin
            crlf_seen = 2'd0;
            ended = 1'b1;
          end else begin
            finish_line();
            crlf_seen = 2'd2;
          end
        end else begin
          // The pending CR was not part of a line break.
          scan_line_char(ASCII_CR);
          if (c == ASCII_CR) crlf_seen = 2'd1;
          else begin
            scan_line_char(c);
            crlf_seen = 2'd0;
          end
        end
      end
      default: begin
        if (c == ASCII_CR) crlf_seen = 2'd3;
        else begin
          scan_line_char(c);
          crlf_seen = 2'd0;
        end
      end
    endcase
    return ended;
  endfunction

  function automatic hrf_out_t predict_frame(logic [7:0] c, logic nc);
    hrf_out_t r;
    bit wrap;
    bit done;
    logic [63:0] body;
    r = '0;
    if (nc) clear_frame_state();
    if (frame_phase == PHASE_HEADER) begin
      wrap = (byte_total == 32'hFFFF_FFFF);
      done = scan_header_byte(c);
      if (!wrap) byte_total++;
      if (wrap || byte_total > lim_header) begin
        r.frame_status = ST_HDR_LARGE;
      end else if (!done) begin
        if (byte_total > lim_request) r.frame_status = ST_TOO_LARGE;
      end else if (len_seen && len_bad) begin
        r.frame_status = ST_BAD_LENGTH;
      end else begin
        body = len_seen ? len_value : 64'd0;
        if (byte_total > lim_request || body > {32'd0, lim_request - byte_total}) begin
          r.frame_status = ST_TOO_LARGE;
        end else if (body == 64'd0) begin
          r.frame_status = ST_DONE;
          r.request_length = byte_total;
          clear_frame_state();
        end else begin
          head_size = byte_total;
          len_value = body;
          frame_phase = PHASE_BODY;
        end
      end
      if (r.frame_status >= ST_HDR_LARGE) frame_phase = PHASE_ERROR;
    end else if (frame_phase == PHASE_BODY) begin
      byte_total++;
      if ({32'd0, byte_total} == {32'd0, head_size} + len_value) begin
        r.frame_status = ST_DONE;
        r.request_length = byte_total;
        r.body_length = len_value[31:0];
        clear_frame_state();
      end
    end else begin
      r.frame_status = ST_DROPPED;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic nc);
    hrf_out_t want;
    int gap;
    gap = idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_item <= '{data_byte: b, new_connection: nc};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    want = predict_frame(b, nc);
    expected_frames.insert(expected_frames.size(), want);
    sent_items++;
  endtask

  task automatic send_message(input logic nc_first, input bit scatter_nc);
    logic nc;
    foreach (request_bytes[i]) begin
      nc = (i == 0) ? nc_first : (scatter_nc && $urandom_range(0, 199) == 0);
      send_byte(request_bytes[i], nc);
    end
  endtask

  // Stops the byte channel and holds until every predicted result is out.
  task automatic wait_idle();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HEADER_LIMIT) lim_header = val;
    else if (idx == CFG_REQUEST_LIMIT) lim_request = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      frame_ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      ready_hold = pick_gap();
      frame_ready <= 1'b0;
    end else begin
      frame_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 200)
      $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && frame_valid && frame_ready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        report_mismatch("result with nothing pending, status", 32'(frame_item.frame_status),
                        32'd0);
      end else begin
        oldest_frame = expected_frames.pop_front();
        if (frame_item.frame_status !== oldest_frame.frame_status)
          report_mismatch("frame_status", 32'(frame_item.frame_status),
                          32'(oldest_frame.frame_status));
        if (frame_item.request_length !== oldest_frame.request_length)
          report_mismatch("request_length", frame_item.request_length,
                          oldest_frame.request_length);
        if (frame_item.body_length !== oldest_frame.body_length)
          report_mismatch("body_length", frame_item.body_length, oldest_frame.body_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- request builders

  function automatic void add_byte(logic [7:0] b);
    request_bytes.insert(request_bytes.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(ASCII_CR);
    add_byte(ASCII_LF);
  endfunction

  function automatic void add_blanks();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) add_byte($urandom_range(0, 1) ? ASCII_SP : ASCII_TAB);
  endfunction

  function automatic void add_mixed_case(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 2) == 0) c = c - 8'd32;
      add_byte(c);
    end
  endfunction

  // Random bytes; crlf_weight sets how often a stray CR or LF shows up.
  function automatic void add_junk(int n, int crlf_weight);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < crlf_weight) add_byte(r[0] ? ASCII_CR : ASCII_LF);
      else if (r < 80) add_byte(8'($urandom_range(33, 126)));
      else if (r < 90) add_byte(r[0] ? ASCII_SP : ASCII_TAB);
      else add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_other_header();
    add_junk($urandom_range(1, 5), 2);
    add_text(":");
    add_junk($urandom_range(0, 6), 2);
    add_crlf();
  endfunction

  function automatic void add_length_name();
    add_blanks();
    add_mixed_case("content-length");
    add_blanks();
    add_text(":");
  endfunction

  function automatic void add_length_value(string digits);
    add_blanks();
    if ($urandom_range(0, 5) == 0) add_text("00");
    add_text(digits);
    add_blanks();
    add_crlf();
  endfunction

  function automatic void add_bad_value();
    add_blanks();
    case ($urandom_range(0, 9))
      0: add_blanks();
      1: add_text("+5");
      2: add_text("-1");
      3: add_text("1 2");
      4: add_text("12a");
      5: add_text("0x10");
      6: add_text("99999999999999999999");
      7: add_text("18446744073709551616");
      8: begin
        add_text("1");
        add_byte(ASCII_CR);
        add_text("2");
      end
      default: add_byte(ASCII_TAB);
    endcase
    add_crlf();
  endfunction

  function automatic void add_near_name();
    add_blanks();
    case ($urandom_range(0, 5))
      0: add_mixed_case("content-lengthx");
      1: add_mixed_case("content-lengt");
      2: add_mixed_case("content length");
      3: add_mixed_case("xcontent-length");
      4: add_mixed_case("content-length-");
      default: add_mixed_case("contentlength");
    endcase
    add_text(":");
  endfunction

  function automatic void add_huge_value();
    case ($urandom_range(0, 3))
      0: add_length_value("4294967296");
      1: add_length_value("18446744073709551615");
      2: add_length_value("4294967295");
      default: add_length_value($sformatf("%0d", {$urandom, $urandom}));
    endcase
  endfunction

  function automatic int unsigned pick_body();
    if ($urandom_range(0, 9) == 0) return $urandom_range(17, 200);
    return $urandom_range(0, 16);
  endfunction

  // Mostly well-formed requests with random content, plus broken ones and noise.
  function automatic void build_request();
    int kind;
    int unsigned body;
    body = 0;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      add_junk($urandom_range(3, 30), 30);
      return;
    end
    case ($urandom_range(0, 2))
      0: add_text("GET /");
      1: add_text("PUT /");
      default: add_text("POST /");
    endcase
    add_junk($urandom_range(0, 3), 0);
    add_text(" HTTP/1.1");
    add_crlf();
    repeat ($urandom_range(0, 2)) add_other_header();
    if (kind < 45) begin
      body = pick_body();
      add_length_name();
      add_length_value($sformatf("%0d", body));
    end else if (kind < 60) begin
      body = 0;
    end else if (kind < 75) begin
      add_length_name();
      add_bad_value();
    end else if (kind < 83) begin
      add_near_name();
      add_length_value($sformatf("%0d", $urandom_range(1, 9)));
    end else if (kind < 90) begin
      // Only the first length line counts.
      body = pick_body();
      add_length_name();
      add_length_value($sformatf("%0d", body));
      add_length_name();
      if ($urandom_range(0, 1) == 0) add_bad_value();
      else add_length_value($sformatf("%0d", $urandom_range(0, 99)));
    end else begin
      add_length_name();
      add_huge_value();
    end
    repeat ($urandom_range(0, 1)) add_other_header();
    add_crlf();
    repeat (body) add_byte(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_empty_request();
    request_bytes.delete();
    add_crlf();
    add_crlf();
    send_message(1'b1, 1'b0);
  endtask

  task automatic test_header_limit();
    write_limit(CFG_HEADER_LIMIT, 32'd2);
    request_bytes.delete();
    add_text("GE");
    add_byte(8'hFF);
    add_byte(8'h00);
    send_message(1'b1, 1'b0);
    write_limit(CFG_HEADER_LIMIT, HEADER_LIMIT_RESET);
  endtask

  task automatic test_request_limit();
    write_limit(CFG_REQUEST_LIMIT, 32'd1);
    request_bytes.delete();
    add_text("ab");
    send_message(1'b1, 1'b0);
    write_limit(CFG_REQUEST_LIMIT, REQUEST_LIMIT_RESET);
  endtask

  task automatic test_length_body();
    request_bytes.delete();
    add_text("Content-Length:1");
    add_crlf();
    add_crlf();
    add_text("Z");
    send_message(1'b1, 1'b0);
  endtask

  // Writes to unknown indexes must leave both limits alone.
  task automatic test_ignored_index();
    write_limit(8'd2, 32'd1);
    write_limit(8'hFF, 32'd1);
    test_empty_request();
  endtask

  task automatic test_random_traffic(input int unsigned target);
    logic nc;
    int unsigned start;
    start = sent_items;
    while (sent_items - start < target) begin
      request_bytes.delete();
      build_request();
      if (frame_phase == PHASE_ERROR) nc = ($urandom_range(0, 4) != 0);
      else nc = ($urandom_range(0, 9) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      send_message(nc, 1'b1);
      if ($urandom_range(0, 19) == 0) wait_idle();
    end
  endtask

  task automatic test_tight_limits();
    logic [31:0] hdr;
    hdr = $urandom_range(30, 90);
    write_limit(CFG_HEADER_LIMIT, hdr);
    write_limit(CFG_REQUEST_LIMIT, hdr + $urandom_range(0, 60));
    test_random_traffic(250);
    write_limit(CFG_REQUEST_LIMIT, hdr - $urandom_range(1, 20));
    test_random_traffic(150);
  endtask

  task automatic test_max_limits();
    write_limit(CFG_HEADER_LIMIT, 32'hFFFF_FFFF);
    write_limit(CFG_REQUEST_LIMIT, 32'hFFFF_FFFF);
    test_random_traffic(400);
  endtask

  task automatic test_min_limits();
    write_limit(CFG_HEADER_LIMIT, 32'd1);
    write_limit(CFG_REQUEST_LIMIT, 32'd1);
    test_random_traffic(60);
  endtask

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    lim_header = HEADER_LIMIT_RESET;
    lim_request = REQUEST_LIMIT_RESET;
    clear_frame_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_request();
    test_header_limit();
    test_request_limit();
    test_length_body();
    test_ignored_index();
    test_random_traffic(620);
    test_tight_limits();
    test_max_limits();
    test_min_limits();

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
